### sv/iec_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iec_pkg : input event coalescer package
// Codes, widths and the types shared by the coalescer's modules.
// ----------------------------------------------------------------------------
package iec_pkg;

   localparam int MAX_STEPS  = 15;
   localparam int RESULT_CAP = 32;

   localparam int STEP_W  = $clog2(MAX_STEPS + 1);
   localparam int DELTA_W = STEP_W + 1;
   localparam int CNT_W   = $clog2(RESULT_CAP + 1);

   localparam int WINDOW_W     = 16;
   localparam int TIME_W       = 32;
   localparam int CODE_W       = 8;
   localparam int INTENSITY_W  = 8;
   localparam int CLASS_W      = 3;
   localparam int COMMAND_W    = 2;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(50);

   typedef enum logic [COMMAND_W-1:0] {
      CMD_EVENT = 2'd0,
      CMD_TICK  = 2'd1,
      CMD_FLUSH = 2'd2,
      CMD_CLEAR = 2'd3
   } command_type;

   typedef enum logic [CLASS_W-1:0] {
      CLS_NONE       = 3'd0,
      CLS_IMMEDIATE  = 3'd1,
      CLS_LEFT       = 3'd2,
      CLS_RIGHT      = 3'd3,
      CLS_UP         = 3'd4,
      CLS_DOWN       = 3'd5,
      CLS_TRIG_LEFT  = 3'd6,
      CLS_TRIG_RIGHT = 3'd7
   } class_type;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [COMMAND_W-1:0]   command;
      logic [CLASS_W-1:0]     event_class;
      logic [CODE_W-1:0]      event_code;
      logic [INTENSITY_W-1:0] intensity;
      logic [TIME_W-1:0]      event_time;
   } req_item_type;

   typedef struct packed {
      logic [CLASS_W-1:0]     out_class;
      logic [CODE_W-1:0]      out_code;
      logic [INTENSITY_W-1:0] out_intensity;
      logic [TIME_W-1:0]      out_time;
      logic                   last;
   } rsp_item_type;

   // controller -> datapath
   typedef struct packed {
      logic start;   // item accepted this cycle
      logic load;    // move next pending result into the output register
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic pending; // results still to be loaded
   } dp_status_type;

endpackage
`default_nettype wire

### sv/iec_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iec_if : coalescer channel interfaces
// Request, response and register-write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface iec_req_if;
   logic                                valid;
   logic                                ready;
   logic [iec_pkg::COMMAND_W-1:0]       command;
   logic [iec_pkg::CLASS_W-1:0]         event_class;
   logic [iec_pkg::CODE_W-1:0]          event_code;
   logic [iec_pkg::INTENSITY_W-1:0]     intensity;
   logic [iec_pkg::TIME_W-1:0]          event_time;

   modport source (output valid, command, event_class, event_code, intensity, event_time,
                   input ready);
   modport sink   (input valid, command, event_class, event_code, intensity, event_time,
                   output ready);
endinterface

interface iec_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [iec_pkg::CLASS_W-1:0]         out_class;
   logic [iec_pkg::CODE_W-1:0]          out_code;
   logic [iec_pkg::INTENSITY_W-1:0]     out_intensity;
   logic [iec_pkg::TIME_W-1:0]          out_time;
   logic                                last;

   modport source (output valid, out_class, out_code, out_intensity, out_time, last,
                   input ready);
   modport sink   (input valid, out_class, out_code, out_intensity, out_time, last,
                   output ready);
endinterface

interface iec_csr_if;
   logic                                valid;
   logic                                ready;
   logic [iec_pkg::WINDOW_W-1:0]        write_data;

   modport source (output valid, write_data, input ready);
   modport sink   (input valid, write_data, output ready);
endinterface
`default_nettype wire

### sv/input_event_coalescer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// input_event_coalescer_top : input event coalescer
// Batches direction and trigger events over a tick window, passes immediates.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                              
//  req_ch    in   command, event_class, event_code, intensity, event_time
//  rsp_ch    out  out_class, out_code, out_intensity, out_time, last
//  csr_ch    in   write_data = window_ms, always ready
//
//  One item at a time; once an item is accepted, its results leave at one a
//  cycle through the single output register while rsp_ch is ready.
//  A stalled rsp_ch holds the sequencer; the last result of an item may sit
//  in the output register while the next item is accepted.
//  Reset (synchronous) sets the window to 50 and closes both batches.
// ----------------------------------------------------------------------------
module input_event_coalescer_top (
   input  wire logic  clock,
   input  wire logic  reset,
   iec_req_if.sink    req_ch,
   iec_rsp_if.source  rsp_ch,
   iec_csr_if.sink    csr_ch
);

   iec_pkg::ctrl_cmd_type  cmd;
   iec_pkg::dp_status_type status;
   iec_pkg::req_item_type  req_item;
   iec_pkg::rsp_item_type  rsp_item;

   assign req_item.command     = req_ch.command;
   assign req_item.event_class = req_ch.event_class;
   assign req_item.event_code  = req_ch.event_code;
   assign req_item.intensity   = req_ch.intensity;
   assign req_item.event_time  = req_ch.event_time;

   assign csr_ch.ready = 1'b1;

   iec_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   iec_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .req_item (req_item),
      .rsp_item (rsp_item),
      .csr_we   (csr_ch.valid),
      .csr_data (csr_ch.write_data)
   );

   assign rsp_ch.out_class     = rsp_item.out_class;
   assign rsp_ch.out_code      = rsp_item.out_code;
   assign rsp_ch.out_intensity = rsp_item.out_intensity;
   assign rsp_ch.out_time      = rsp_item.out_time;
   assign rsp_ch.last          = rsp_item.last;

endmodule
`default_nettype wire

### sv/iec_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iec_ctrl : coalescer controller
// Accepts one item at a time, then paces result loads into the output register.
// ----------------------------------------------------------------------------
module iec_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire iec_pkg::dp_status_type status,
   output      iec_pkg::ctrl_cmd_type  cmd
);

   iec_pkg::state_type state_ff, state_in;
   logic               out_vld_ff, out_vld_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= iec_pkg::ST_IDLE;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         iec_pkg::ST_IDLE: begin
            if (req_valid) state_in = iec_pkg::ST_EMIT;
         end
         iec_pkg::ST_EMIT: begin
            if (!status.pending) state_in = iec_pkg::ST_IDLE;
         end
         default: state_in = iec_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      cmd.start  = 1'b0;
      cmd.load   = 1'b0;
      unique case (state_ff)
         iec_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.start = req_valid;
         end
         iec_pkg::ST_EMIT: begin
            cmd.load = status.pending && (!out_vld_ff || rsp_ready);
         end
         default: ;
      endcase
   end

   // output register stays full until taken; a load refills it in the same cycle
   always_comb begin
      out_vld_in = out_vld_ff;
      if (cmd.load)      out_vld_in = 1'b1;
      else if (rsp_ready) out_vld_in = 1'b0;
   end

   assign rsp_valid = out_vld_ff;

endmodule
`default_nettype wire

### sv/iec_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iec_dp : coalescer datapath
// Batch state, window check, pending results and the output register.
// ----------------------------------------------------------------------------
module iec_dp (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire iec_pkg::ctrl_cmd_type           cmd,
   output      iec_pkg::dp_status_type          status,
   input  wire iec_pkg::req_item_type           req_item,
   output      iec_pkg::rsp_item_type           rsp_item,
   input  wire logic                            csr_we,
   input  wire logic [iec_pkg::WINDOW_W-1:0]    csr_data
);

   localparam logic signed [iec_pkg::DELTA_W-1:0] DELTA_MAX =
      iec_pkg::DELTA_W'(iec_pkg::MAX_STEPS);
   localparam logic signed [iec_pkg::DELTA_W-1:0] DELTA_MIN = -DELTA_MAX;
   localparam logic signed [iec_pkg::DELTA_W-1:0] DELTA_ONE = iec_pkg::DELTA_W'(1);

   // configuration and batch state
   logic [iec_pkg::WINDOW_W-1:0]          window_ff;
   logic [iec_pkg::TIME_W-1:0]            now_ff, now_in;
   logic                                  nav_open_ff, nav_open_in;
   logic [iec_pkg::TIME_W-1:0]            nav_start_ff, nav_start_in;
   logic signed [iec_pkg::DELTA_W-1:0]    dx_ff, dx_in, dy_ff, dy_in;
   logic                                  trig_open_ff, trig_open_in;
   logic [iec_pkg::TIME_W-1:0]            trig_start_ff, trig_start_in;
   logic [iec_pkg::INTENSITY_W-1:0]       left_ff, left_in, right_ff, right_in;

   // pending results of the current item
   logic [iec_pkg::STEP_W-1:0]            cnt_x_ff, cnt_x_in, cnt_y_ff, cnt_y_in;
   logic [iec_pkg::CLASS_W-1:0]           x_cls_ff, x_cls_in, y_cls_ff, y_cls_in;
   logic                                  pend_l_ff, pend_l_in, pend_r_ff, pend_r_in;
   logic [iec_pkg::INTENSITY_W-1:0]       lval_ff, lval_in, rval_ff, rval_in;
   logic                                  pend_imm_ff, pend_imm_in;
   logic [iec_pkg::CODE_W-1:0]            imm_code_ff, imm_code_in;
   logic [iec_pkg::INTENSITY_W-1:0]       imm_int_ff, imm_int_in;
   logic [iec_pkg::TIME_W-1:0]            imm_time_ff, imm_time_in;
   logic [iec_pkg::CNT_W-1:0]             emit_cnt_ff, emit_cnt_in;

   iec_pkg::rsp_item_type                 out_ff, out_in;

   logic                                  nav_fire, trig_fire, more, cap_hit;
   logic signed [iec_pkg::DELTA_W-1:0]    dx_base, dy_base;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff     <= iec_pkg::WINDOW_RESET;
         now_ff        <= '0;
         nav_open_ff   <= 1'b0;
         nav_start_ff  <= '0;
         dx_ff         <= '0;
         dy_ff         <= '0;
         trig_open_ff  <= 1'b0;
         trig_start_ff <= '0;
         left_ff       <= '0;
         right_ff      <= '0;
         cnt_x_ff      <= '0;
         cnt_y_ff      <= '0;
         pend_l_ff     <= 1'b0;
         pend_r_ff     <= 1'b0;
         pend_imm_ff   <= 1'b0;
         emit_cnt_ff   <= '0;
      end else begin
         if (csr_we) window_ff <= csr_data;
         now_ff        <= now_in;
         nav_open_ff   <= nav_open_in;
         nav_start_ff  <= nav_start_in;
         dx_ff         <= dx_in;
         dy_ff         <= dy_in;
         trig_open_ff  <= trig_open_in;
         trig_start_ff <= trig_start_in;
         left_ff       <= left_in;
         right_ff      <= right_in;
         cnt_x_ff      <= cnt_x_in;
         cnt_y_ff      <= cnt_y_in;
         pend_l_ff     <= pend_l_in;
         pend_r_ff     <= pend_r_in;
         pend_imm_ff   <= pend_imm_in;
         emit_cnt_ff   <= emit_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_cls_ff    <= x_cls_in;
      y_cls_ff    <= y_cls_in;
      lval_ff     <= lval_in;
      rval_ff     <= rval_in;
      imm_code_ff <= imm_code_in;
      imm_int_ff  <= imm_int_in;
      imm_time_ff <= imm_time_in;
      out_ff      <= out_in;
   end

   always_comb begin
      now_in        = now_ff;
      nav_open_in   = nav_open_ff;
      nav_start_in  = nav_start_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      trig_open_in  = trig_open_ff;
      trig_start_in = trig_start_ff;
      left_in       = left_ff;
      right_in      = right_ff;
      cnt_x_in      = cnt_x_ff;
      cnt_y_in      = cnt_y_ff;
      x_cls_in      = x_cls_ff;
      y_cls_in      = y_cls_ff;
      pend_l_in     = pend_l_ff;
      pend_r_in     = pend_r_ff;
      lval_in       = lval_ff;
      rval_in       = rval_ff;
      pend_imm_in   = pend_imm_ff;
      imm_code_in   = imm_code_ff;
      imm_int_in    = imm_int_ff;
      imm_time_in   = imm_time_ff;
      emit_cnt_in   = emit_cnt_ff;
      out_in        = out_ff;
      nav_fire      = 1'b0;
      trig_fire     = 1'b0;
      more          = 1'b0;
      cap_hit       = 1'b0;
      dx_base       = nav_open_ff ? dx_ff : '0;
      dy_base       = nav_open_ff ? dy_ff : '0;

      if (cmd.start) begin
         emit_cnt_in = '0;
         case (req_item.command)
            iec_pkg::CMD_EVENT: begin
               case (req_item.event_class) inside
                  iec_pkg::CLS_IMMEDIATE: begin
                     pend_imm_in = 1'b1;
                     imm_code_in = req_item.event_code;
                     imm_int_in  = req_item.intensity;
                     imm_time_in = req_item.event_time;
                  end
                  iec_pkg::CLS_LEFT, iec_pkg::CLS_RIGHT,
                  iec_pkg::CLS_UP, iec_pkg::CLS_DOWN: begin
                     if (!nav_open_ff) nav_start_in = now_ff;
                     nav_open_in = 1'b1;
                     dx_in       = dx_base;
                     dy_in       = dy_base;
                     if (req_item.event_class == iec_pkg::CLS_LEFT && dx_base > DELTA_MIN)
                        dx_in = dx_base - DELTA_ONE;
                     if (req_item.event_class == iec_pkg::CLS_RIGHT && dx_base < DELTA_MAX)
                        dx_in = dx_base + DELTA_ONE;
                     if (req_item.event_class == iec_pkg::CLS_UP && dy_base > DELTA_MIN)
                        dy_in = dy_base - DELTA_ONE;
                     if (req_item.event_class == iec_pkg::CLS_DOWN && dy_base < DELTA_MAX)
                        dy_in = dy_base + DELTA_ONE;
                  end
                  iec_pkg::CLS_TRIG_LEFT, iec_pkg::CLS_TRIG_RIGHT: begin
                     if (!trig_open_ff) begin
                        trig_start_in = now_ff;
                        left_in       = '0;
                        right_in      = '0;
                     end
                     trig_open_in = 1'b1;
                     if (req_item.event_class == iec_pkg::CLS_TRIG_LEFT)
                        left_in = req_item.intensity;
                     else
                        right_in = req_item.intensity;
                  end
                  default: ;
               endcase
            end
            iec_pkg::CMD_TICK: begin
               now_in    = now_ff + 1'b1;
               // ages are taken mod 2^32 after the tick
               nav_fire  = nav_open_ff &&
                           ((now_in - nav_start_ff) >= iec_pkg::TIME_W'(window_ff));
               trig_fire = trig_open_ff &&
                           ((now_in - trig_start_ff) >= iec_pkg::TIME_W'(window_ff));
            end
            iec_pkg::CMD_FLUSH: begin
               nav_fire  = nav_open_ff;
               trig_fire = trig_open_ff;
            end
            default: begin
               nav_open_in  = 1'b0;
               dx_in        = '0;
               dy_in        = '0;
               trig_open_in = 1'b0;
               left_in      = '0;
               right_in     = '0;
            end
         endcase

         if (nav_fire) begin
            cnt_x_in    = dx_ff[iec_pkg::DELTA_W-1] ? iec_pkg::STEP_W'(-dx_ff)
                                                   : iec_pkg::STEP_W'(dx_ff);
            cnt_y_in    = dy_ff[iec_pkg::DELTA_W-1] ? iec_pkg::STEP_W'(-dy_ff)
                                                   : iec_pkg::STEP_W'(dy_ff);
            x_cls_in    = dx_ff[iec_pkg::DELTA_W-1] ? iec_pkg::CLS_LEFT : iec_pkg::CLS_RIGHT;
            y_cls_in    = dy_ff[iec_pkg::DELTA_W-1] ? iec_pkg::CLS_UP : iec_pkg::CLS_DOWN;
            dx_in       = '0;
            dy_in       = '0;
            nav_open_in = 1'b0;
         end
         if (trig_fire) begin
            pend_l_in    = (left_ff != '0);
            pend_r_in    = (right_ff != '0);
            lval_in      = left_ff;
            rval_in      = right_ff;
            left_in      = '0;
            right_in     = '0;
            trig_open_in = 1'b0;
         end
      end else if (cmd.load) begin
         out_in.out_code      = '0;
         out_in.out_intensity = '0;
         out_in.out_time      = now_ff;
         if (pend_imm_ff) begin
            out_in.out_class     = iec_pkg::CLS_IMMEDIATE;
            out_in.out_code      = imm_code_ff;
            out_in.out_intensity = imm_int_ff;
            out_in.out_time      = imm_time_ff;
            pend_imm_in          = 1'b0;
         end else if (cnt_x_ff != '0) begin
            out_in.out_class = x_cls_ff;
            cnt_x_in         = cnt_x_ff - iec_pkg::STEP_W'(1);
         end else if (cnt_y_ff != '0) begin
            out_in.out_class = y_cls_ff;
            cnt_y_in         = cnt_y_ff - iec_pkg::STEP_W'(1);
         end else if (pend_l_ff) begin
            out_in.out_class     = iec_pkg::CLS_TRIG_LEFT;
            out_in.out_intensity = lval_ff;
            pend_l_in            = 1'b0;
         end else begin
            out_in.out_class     = iec_pkg::CLS_TRIG_RIGHT;
            out_in.out_intensity = rval_ff;
            pend_r_in            = 1'b0;
         end

         more        = pend_imm_in || (cnt_x_in != '0) || (cnt_y_in != '0) ||
                       pend_l_in || pend_r_in;
         emit_cnt_in = emit_cnt_ff + iec_pkg::CNT_W'(1);
         // results past the cap are dropped
         cap_hit     = (emit_cnt_in == iec_pkg::CNT_W'(iec_pkg::RESULT_CAP));
         out_in.last = !more || cap_hit;
         if (cap_hit) begin
            pend_imm_in = 1'b0;
            cnt_x_in    = '0;
            cnt_y_in    = '0;
            pend_l_in   = 1'b0;
            pend_r_in   = 1'b0;
         end
      end
   end

   assign status.pending = pend_imm_ff || (cnt_x_ff != '0) || (cnt_y_ff != '0) ||
                           pend_l_ff || pend_r_ff;
   assign rsp_item       = out_ff;

endmodule
`default_nettype wire

### dv/input_event_coalescer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// input_event_coalescer_top_tb : self-checking bench for the event coalescer
// Event items are queued by a stimulus process and driven onto the request
// channel. Each accepted item runs through a behavioural copy of the
// coalescer, and every result that comes back is compared field by field.
// The window register is rewritten between phases, including its extremes.
// ----------------------------------------------------------------------------
module input_event_coalescer_top_tb;
   import iec_pkg::*;

   logic clock;
   logic reset;

   iec_req_if req_ch ();
   iec_rsp_if rsp_ch ();
   iec_csr_if csr_ch ();

   input_event_coalescer_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // behavioural copy of the coalescer state
   logic [WINDOW_W-1:0]           window_cfg = WINDOW_RESET;
   logic [TIME_W-1:0]             now_ticks = '0;
   logic                          nav_open = 1'b0;
   logic [TIME_W-1:0]             nav_start = '0;
   logic signed [DELTA_W-1:0]     net_x = '0;
   logic signed [DELTA_W-1:0]     net_y = '0;
   logic                          trig_open = 1'b0;
   logic [TIME_W-1:0]             trig_start = '0;
   logic [INTENSITY_W-1:0]        left_level = '0;
   logic [INTENSITY_W-1:0]        right_level = '0;

   rsp_item_type step_results[$];
   rsp_item_type expected_events[$];
   req_item_type pending_reqs[$];

   int  reqs_queued = 0;
   int  reqs_accepted = 0;
   int  random_items = 0;
   int  mismatches = 0;
   int  idle_pct = 7;
   bit  hold_go = 1'b0;
   logic rsp_hold = 1'b0;
   req_item_type cur_req;

   // ---------------------------------------------------------------- predictor
   function void put_result(class_type cls, logic [CODE_W-1:0] code,
                            logic [INTENSITY_W-1:0] level, logic [TIME_W-1:0] stamp);
      rsp_item_type r;
      if (step_results.size() >= RESULT_CAP) return;
      r.out_class     = cls;
      r.out_code      = code;
      r.out_intensity = level;
      r.out_time      = stamp;
      r.last          = 1'b0;
      step_results    = {step_results, r};
   endfunction

   function void emit_steps(logic signed [DELTA_W-1:0] net, class_type neg_cls,
                            class_type pos_cls);
      int n;
      n = (net < 0) ? -int'(net) : int'(net);
      repeat (n) put_result((net > 0) ? pos_cls : neg_cls, '0, '0, now_ticks);
   endfunction

   function void emit_nav_batch();
      emit_steps(net_x, CLS_LEFT, CLS_RIGHT);
      emit_steps(net_y, CLS_UP, CLS_DOWN);
      net_x    = '0;
      net_y    = '0;
      nav_open = 1'b0;
   endfunction

   function void emit_trig_batch();
      if (left_level != 0) put_result(CLS_TRIG_LEFT, '0, left_level, now_ticks);
      if (right_level != 0) put_result(CLS_TRIG_RIGHT, '0, right_level, now_ticks);
      left_level  = '0;
      right_level = '0;
      trig_open   = 1'b0;
   endfunction

   function void coalesce_predict(req_item_type it);
      class_type cls;
      cls = class_type'(it.event_class);
      step_results.delete();
      case (command_type'(it.command))
         CMD_EVENT: begin
            if (cls == CLS_IMMEDIATE) begin
               put_result(cls, it.event_code, it.intensity, it.event_time);
            end else if (cls >= CLS_LEFT && cls <= CLS_DOWN) begin
               if (!nav_open) begin
                  nav_start = now_ticks;
                  net_x     = '0;
                  net_y     = '0;
                  nav_open  = 1'b1;
               end
               if (cls == CLS_LEFT && net_x > -MAX_STEPS) net_x = DELTA_W'(net_x - 1);
               if (cls == CLS_RIGHT && net_x < MAX_STEPS) net_x = DELTA_W'(net_x + 1);
               if (cls == CLS_UP && net_y > -MAX_STEPS) net_y = DELTA_W'(net_y - 1);
               if (cls == CLS_DOWN && net_y < MAX_STEPS) net_y = DELTA_W'(net_y + 1);
            end else if (cls == CLS_TRIG_LEFT || cls == CLS_TRIG_RIGHT) begin
               if (!trig_open) begin
                  trig_start  = now_ticks;
                  left_level  = '0;
                  right_level = '0;
                  trig_open   = 1'b1;
               end
               if (cls == CLS_TRIG_LEFT) left_level = it.intensity;
               else right_level = it.intensity;
            end
         end
         CMD_TICK: begin
            now_ticks = now_ticks + 1;
            if (nav_open && (now_ticks - nav_start) >= TIME_W'(window_cfg))
               emit_nav_batch();
            if (trig_open && (now_ticks - trig_start) >= TIME_W'(window_cfg))
               emit_trig_batch();
         end
         CMD_FLUSH: begin
            if (nav_open) emit_nav_batch();
            if (trig_open) emit_trig_batch();
         end
         default: begin
            nav_open    = 1'b0;
            net_x       = '0;
            net_y       = '0;
            trig_open   = 1'b0;
            left_level  = '0;
            right_level = '0;
         end
      endcase
      if (step_results.size() > 0) step_results[step_results.size()-1].last = 1'b1;
      expected_events = {expected_events, step_results};
   endfunction

   // ---------------------------------------------------------------- clock, limit
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

   // known values on every input from time zero
   initial begin
      req_ch.valid       = 1'b0;
      req_ch.command     = CMD_EVENT;
      req_ch.event_class = CLS_NONE;
      req_ch.event_code  = '0;
      req_ch.intensity   = '0;
      req_ch.event_time  = '0;
      rsp_ch.ready       = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.write_data  = '0;
   end

   // ---------------------------------------------------------------- driver
   always @(posedge clock) begin : req_driver
      bit taken;
      taken = req_ch.valid && req_ch.ready;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (taken) begin
            coalesce_predict(cur_req);
            reqs_accepted++;
         end
         if (!req_ch.valid || taken) begin
            if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
               cur_req = pending_reqs.pop_front();
               req_ch.valid       <= 1'b1;
               req_ch.command     <= cur_req.command;
               req_ch.event_class <= cur_req.event_class;
               req_ch.event_code  <= cur_req.event_code;
               req_ch.intensity   <= cur_req.intensity;
               req_ch.event_time  <= cur_req.event_time;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin : rsp_monitor
      rsp_item_type got;
      rsp_item_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.out_class     = rsp_ch.out_class;
            got.out_code      = rsp_ch.out_code;
            got.out_intensity = rsp_ch.out_intensity;
            got.out_time      = rsp_ch.out_time;
            got.last          = rsp_ch.last;
            if (expected_events.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected item cls=%0d code=%h int=%h t=%h last=%b",
                           $realtime, got.out_class, got.out_code, got.out_intensity,
                           got.out_time, got.last);
            end else begin
               want = expected_events.pop_front();
               if (got.out_class !== want.out_class || got.out_code !== want.out_code ||
                   got.out_intensity !== want.out_intensity ||
                   got.out_time !== want.out_time || got.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"%0t: item mismatch exp cls=%0d code=%h int=%h t=%h last=%b",
                               " got cls=%0d code=%h int=%h t=%h last=%b"},
                              $realtime, want.out_class, want.out_code, want.out_intensity,
                              want.out_time, want.last, got.out_class, got.out_code,
                              got.out_intensity, got.out_time, got.last);
               end
            end
         end
         rsp_ch.ready <= !rsp_hold && ($urandom_range(0, 99) >= idle_pct);
      end
   end

   // long receiver stall, counted here so the sender keeps offering meanwhile
   initial begin : rsp_stall
      wait (hold_go);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (300) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // ---------------------------------------------------------------- stimulus
   task automatic queue_req(command_type cmd, class_type cls, logic [CODE_W-1:0] code,
                            logic [INTENSITY_W-1:0] level, logic [TIME_W-1:0] stamp);
      req_item_type it;
      it.command     = cmd;
      it.event_class = cls;
      it.event_code  = code;
      it.intensity   = level;
      it.event_time  = stamp;
      pending_reqs   = {pending_reqs, it};
      reqs_queued++;
      if (!(cmd == CMD_EVENT && cls == CLS_NONE)) random_items++;
   endtask

   task automatic queue_event(class_type cls);
      queue_req(CMD_EVENT, cls, CODE_W'($urandom_range(0, 255)),
                INTENSITY_W'($urandom_range(0, 255)), $urandom());
   endtask

   // commands other than events carry random, unused fields
   task automatic queue_event_cmd(command_type cmd);
      queue_req(cmd, class_type'($urandom_range(0, 7)), CODE_W'($urandom_range(0, 255)),
                INTENSITY_W'($urandom_range(0, 255)), $urandom());
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (reqs_accepted != reqs_queued || expected_events.size() != 0);
   endtask

   task automatic write_window(logic [WINDOW_W-1:0] value);
      wait_drained();
      // an item without results may still be in the sequencer
      repeat (8) @(posedge clock);
      csr_ch.valid      <= 1'b1;
      csr_ch.write_data <= value;
      do @(posedge clock);
      while (!csr_ch.ready);
      window_cfg = value;
      csr_ch.valid <= 1'b0;
   endtask

   // a burst of direction traffic closed by ticks, a flush or a clear; some noise
   task automatic queue_burst();
      int        pick;
      int        n;
      int        tick_max;
      class_type heading;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         queue_req(command_type'($urandom_range(0, 3)), class_type'($urandom_range(0, 7)),
                   CODE_W'($urandom_range(0, 255)), INTENSITY_W'($urandom_range(0, 255)),
                   $urandom());
         return;
      end
      n       = (pick < 30) ? $urandom_range(14, 20) : $urandom_range(1, 6);
      heading = class_type'($urandom_range(CLS_LEFT, CLS_DOWN));
      repeat (n) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) queue_event(heading);
         else if (pick < 80) queue_event(class_type'($urandom_range(CLS_LEFT, CLS_DOWN)));
         else if (pick < 90) queue_event(class_type'($urandom_range(CLS_TRIG_LEFT,
                                                                    CLS_TRIG_RIGHT)));
         else queue_event(CLS_IMMEDIATE);
      end
      pick     = $urandom_range(0, 99);
      tick_max = (window_cfg < 10) ? int'(window_cfg) + 1 : 10;
      if (pick < 70) begin
         repeat ($urandom_range(0, tick_max)) queue_event_cmd(CMD_TICK);
      end else if (pick < 90) begin
         queue_event_cmd(CMD_FLUSH);
      end else begin
         queue_event_cmd(CMD_CLEAR);
      end
   endtask

   task automatic run_random(int amount);
      int goal;
      goal = random_items + amount;
      while (random_items < goal) queue_burst();
   endtask

   initial begin : main_seq
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed part, window of two ticks
      write_window(2);
      queue_req(CMD_EVENT, CLS_IMMEDIATE, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
      queue_req(CMD_EVENT, CLS_IMMEDIATE, 8'h00, 8'h00, 32'h0000_0000);
      queue_req(CMD_EVENT, CLS_NONE, 8'hA5, 8'h5A, 32'h1234_5678);
      queue_event(CLS_LEFT);
      queue_event(CLS_RIGHT);
      queue_event_cmd(CMD_FLUSH);              // nets cancel: nothing comes out
      queue_event(CLS_UP);
      queue_req(CMD_EVENT, CLS_TRIG_LEFT, 8'h00, 8'hFF, 32'h0);
      queue_req(CMD_EVENT, CLS_TRIG_RIGHT, 8'hFF, 8'h00, 32'hFFFF_FFFF);
      queue_event_cmd(CMD_TICK);
      queue_event_cmd(CMD_TICK);               // window expires
      queue_event(CLS_DOWN);
      queue_req(CMD_EVENT, CLS_TRIG_RIGHT, 8'h00, 8'h80, 32'h0);
      queue_event_cmd(CMD_CLEAR);
      queue_event_cmd(CMD_TICK);
      queue_event(CLS_LEFT);
      queue_event(CLS_LEFT);
      queue_event_cmd(CMD_FLUSH);
      queue_event_cmd(CMD_FLUSH);              // nothing open
      write_window(0);
      queue_event(CLS_RIGHT);
      queue_event(CLS_RIGHT);                  // events alone never expire
      queue_event_cmd(CMD_TICK);
      queue_req(CMD_EVENT, CLS_TRIG_LEFT, 8'h00, 8'h01, 32'h0);
      queue_event_cmd(CMD_TICK);

      random_items = 0;
      run_random(60);
      write_window(16'hFFFF);
      run_random(40);
      queue_event_cmd(CMD_FLUSH);

      // stretch without idling on either side
      write_window(1);
      idle_pct <= 0;
      run_random(80);
      wait_drained();
      idle_pct <= 7;

      write_window(WINDOW_RESET);
      run_random(50);

      // receiver holds off while the sender keeps pushing
      write_window(3);
      hold_go = 1'b1;
      run_random(80);

      repeat (3) begin
         write_window(WINDOW_W'($urandom_range(1, 6)));
         run_random(50);
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
